// ===== src/e2p_pkg.sv =====
package e2p_pkg;

	// panorama geometry; height is a power of two so that the index wraps in IDX_W bits
	localparam int PANO_HEIGHT = 1024;
	localparam int IDX_W = $clog2(2 * PANO_HEIGHT);
	localparam int ANG_SHIFT = 32 - IDX_W;

	// trig
	localparam int TRIG_FRAC_BITS = 16;
	localparam int TRIG_W = TRIG_FRAC_BITS + 2;
	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_W = 34;
	localparam int CORDIC_GAIN_Q30 = 652032874;
	localparam int RND_SHIFT = 30 - TRIG_FRAC_BITS;
	localparam int CORDIC_LAT = CORDIC_STEPS + 2;

	// projection
	localparam int COEF_W = 21;
	localparam int TERM_W = COEF_W + TRIG_W;
	localparam int PROJ_W = TERM_W + 2;
	localparam int POS_W = PROJ_W - 1;
	localparam int SIZE_W = 13;
	localparam int PROD_W = PROJ_W + SIZE_W + 1;
	localparam int EXT_W = PROD_W + 1;
	localparam int NUM_W = POS_W + SIZE_W;
	localparam int QUOT_W = SIZE_W;
	localparam int COORD_W = 12;
	localparam int FRONT_LAT = CORDIC_LAT + 7;

	// configuration port
	localparam int CFG_W = 3 * COEF_W;
	localparam int CFG_IDX_W = 3;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_ZERO   = 3'd0,
		REG_ROW_ONE    = 3'd1,
		REG_ROW_TWO    = 3'd2,
		REG_SRC_WIDTH  = 3'd3,
		REG_SRC_HEIGHT = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [10:0] pano_col;
		logic [9:0]  pano_row;
	} pano_t;

	typedef struct packed {
		logic [COORD_W-1:0] source_col;
		logic [COORD_W-1:0] source_row;
		logic               row_inside;
		logic               col_inside;
	} result_t;

	typedef struct packed {
		logic [CFG_W-1:0]  row_zero;
		logic [CFG_W-1:0]  row_one;
		logic [CFG_W-1:0]  row_two;
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
	} cfg_t;

	// one classified item waiting for its two divisions
	typedef struct packed {
		logic [NUM_W-1:0] col_num;
		logic [NUM_W-1:0] row_num;
		logic [POS_W-1:0] w;
		logic             col_inside;
		logic             row_inside;
	} work_t;

	// arctangent of 2^-i in binary angle units of 2^32 per turn
	function automatic logic signed [CORDIC_W-1:0] atan_brad(input int i);
		logic signed [CORDIC_W-1:0] a;
		unique case (i)
			0: a = 34'sd536870912;
			1: a = 34'sd316933406;
			2: a = 34'sd167458907;
			3: a = 34'sd85004756;
			4: a = 34'sd42667331;
			5: a = 34'sd21354465;
			6: a = 34'sd10679838;
			7: a = 34'sd5340245;
			8: a = 34'sd2670163;
			9: a = 34'sd1335087;
			10: a = 34'sd667544;
			11: a = 34'sd333772;
			12: a = 34'sd166886;
			13: a = 34'sd83443;
			14: a = 34'sd41722;
			15: a = 34'sd20861;
			16: a = 34'sd10430;
			17: a = 34'sd5215;
			18: a = 34'sd2608;
			19: a = 34'sd1304;
			20: a = 34'sd652;
			21: a = 34'sd326;
			22: a = 34'sd163;
			23: a = 34'sd81;
			24: a = 34'sd41;
			25: a = 34'sd20;
			26: a = 34'sd10;
			27: a = 34'sd5;
			28: a = 34'sd3;
			29: a = 34'sd1;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== src/equirect_to_pinhole_mapper.sv =====
// channel   | ports                              | handshake
// ----------+------------------------------------+-------------------------------------
// pixel in  | start, busy, pano                  | item taken when start and not busy
// result    | done, result                       | one cycle strobe, cannot be held off
// config    | cfg_we, cfg_index, cfg_data        | written on any edge with cfg_we high
//
// one item per clock; an item passes the two cordic pipelines, then direction,
// projection and classification, then the queue, then the divider
// reset clears the pipeline valids and the queue pointers and loads the configuration defaults
// busy rises only if the queue fills, which the divider never lets happen since it
// drains one item every cycle; the result side has no stall
module equirect_to_pinhole_mapper (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  e2p_pkg::pano_t                      pano,
	output logic                                done,
	output e2p_pkg::result_t                    result,
	input  logic                                cfg_we,
	input  logic [e2p_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [e2p_pkg::CFG_W-1:0]           cfg_data
);

	e2p_pkg::cfg_t  cfg_q;
	logic           accept;
	logic           front_valid;
	e2p_pkg::work_t front_work;
	logic           queue_valid;
	e2p_pkg::work_t queue_item;
	logic           queue_full;

	// configuration registers, matrix rows pack three q12.8 coefficients each
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_zero <= '0;
			cfg_q.row_one  <= '0;
			cfg_q.row_two  <= '0;
			cfg_q.width    <= e2p_pkg::SIZE_W'(720);
			cfg_q.height   <= e2p_pkg::SIZE_W'(1280);
		end else if (cfg_we) begin
			unique case (e2p_pkg::cfg_reg_t'(cfg_index))
				e2p_pkg::REG_ROW_ZERO:   cfg_q.row_zero <= cfg_data;
				e2p_pkg::REG_ROW_ONE:    cfg_q.row_one  <= cfg_data;
				e2p_pkg::REG_ROW_TWO:    cfg_q.row_two  <= cfg_data;
				e2p_pkg::REG_SRC_WIDTH:  cfg_q.width    <= cfg_data[e2p_pkg::SIZE_W-1:0];
				e2p_pkg::REG_SRC_HEIGHT: cfg_q.height   <= cfg_data[e2p_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy   = queue_full;
	assign accept = start && !busy;

	// front: trig, direction, projection and bounds classification
	e2p_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.pano      (pano),
		.cfg       (cfg_q),
		.out_valid (front_valid),
		.work      (front_work)
	);

	// short queue decouples the front from the divider
	e2p_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_item (front_work),
		.pop       (queue_valid),
		.out_valid (queue_valid),
		.out_item  (queue_item),
		.full      (queue_full)
	);

	// back: the two perspective divides
	e2p_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (queue_valid),
		.item     (queue_item),
		.done     (done),
		.result   (result)
	);

endmodule

// ===== src/e2p_cordic.sv =====
module e2p_cordic (
	input  logic                                   clk,
	input  logic [e2p_pkg::IDX_W-1:0]              idx,
	output logic signed [e2p_pkg::TRIG_W-1:0]      sin_val,
	output logic signed [e2p_pkg::TRIG_W-1:0]      cos_val
);

	localparam int N = e2p_pkg::CORDIC_STEPS;
	localparam int W = e2p_pkg::CORDIC_W;
	localparam logic signed [W-1:0] GAIN = W'(e2p_pkg::CORDIC_GAIN_Q30);
	localparam logic signed [W-1:0] RND_HALF = W'(1) << (e2p_pkg::RND_SHIFT - 1);

	logic signed [W-1:0] x_s [0:N];
	logic signed [W-1:0] y_s [0:N];
	logic signed [W-1:0] z_s [0:N];
	logic                flip_s [0:N];

	logic [31:0]         ang;
	logic                half_turn;
	logic [31:0]         ang_fold;
	logic signed [W-1:0] xr;
	logic signed [W-1:0] yr;

	// fold the left half plane onto the right, undo by negation at the end
	assign ang       = {idx, {e2p_pkg::ANG_SHIFT{1'b0}}};
	assign half_turn = ang[31] ^ ang[30];
	assign ang_fold  = half_turn ? {~ang[31], ang[30:0]} : ang;

	always_ff @(posedge clk) begin
		x_s[0]    <= GAIN;
		y_s[0]    <= '0;
		z_s[0]    <= W'($signed(ang_fold));
		flip_s[0] <= half_turn;
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (!z_s[i][W-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - e2p_pkg::atan_brad(i);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + e2p_pkg::atan_brad(i);
			end
			flip_s[i+1] <= flip_s[i];
		end
	end

	assign xr = (x_s[N] + RND_HALF) >>> e2p_pkg::RND_SHIFT;
	assign yr = (y_s[N] + RND_HALF) >>> e2p_pkg::RND_SHIFT;

	always_ff @(posedge clk) begin
		if (flip_s[N]) begin
			cos_val <= -e2p_pkg::TRIG_W'(xr);
			sin_val <= -e2p_pkg::TRIG_W'(yr);
		end else begin
			cos_val <= e2p_pkg::TRIG_W'(xr);
			sin_val <= e2p_pkg::TRIG_W'(yr);
		end
	end

endmodule

// ===== src/e2p_front.sv =====
module e2p_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  e2p_pkg::pano_t       pano,
	input  e2p_pkg::cfg_t        cfg,
	output logic                 out_valid,
	output e2p_pkg::work_t       work
);

	localparam int TW = e2p_pkg::TRIG_W;
	localparam int CW = e2p_pkg::COEF_W;
	localparam int PW = e2p_pkg::PROJ_W;
	localparam int XW = e2p_pkg::EXT_W;
	localparam int DW = e2p_pkg::PROD_W;
	localparam logic signed [2*TW-1:0] D_HALF = (2*TW)'(1) << (e2p_pkg::TRIG_FRAC_BITS - 1);

	logic [e2p_pkg::FRONT_LAT-1:0] v_q;

	logic [e2p_pkg::IDX_W-1:0] th_idx;
	logic [e2p_pkg::IDX_W-1:0] ph_idx;
	logic signed [TW-1:0] sin_t, cos_t, sin_p, cos_p;

	logic signed [2*TW-1:0] pc_s1, ps_s1;
	logic signed [TW-1:0]   cp_s1;
	logic signed [TW-1:0]   d_s2 [3];
	logic signed [e2p_pkg::TERM_W-1:0] term_s3 [3][3];
	logic signed [PW-1:0]   proj_s4 [3];
	logic signed [DW-1:0]   cm_s5, cl_s5, rl_s5;
	logic signed [PW-1:0]   u_s5, v_s5, w_s5;
	logic signed [XW-1:0]   ncol_s6, cl_s6, rl_s6, v_s6, w_s6;

	logic signed [CW-1:0]     coef [3][3];
	logic signed [2*TW-1:0]   d0_full, d1_full;
	logic signed [e2p_pkg::SIZE_W:0] sw_m1;
	logic wpos, cin, rin;

	// longitude starts at minus pi
	assign th_idx = pano.pano_col + e2p_pkg::IDX_W'(e2p_pkg::PANO_HEIGHT);
	assign ph_idx = e2p_pkg::IDX_W'(pano.pano_row);

	e2p_cordic u_cordic_theta (.clk(clk), .idx(th_idx), .sin_val(sin_t), .cos_val(cos_t));
	e2p_cordic u_cordic_phi   (.clk(clk), .idx(ph_idx), .sin_val(sin_p), .cos_val(cos_p));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[e2p_pkg::FRONT_LAT-2:0], in_valid};
		end
	end

	// direction vector
	always_ff @(posedge clk) begin
		pc_s1 <= cos_t * sin_p;
		ps_s1 <= sin_t * sin_p;
		cp_s1 <= cos_p;
	end

	assign d0_full = (pc_s1 + D_HALF) >>> e2p_pkg::TRIG_FRAC_BITS;
	assign d1_full = (ps_s1 + D_HALF) >>> e2p_pkg::TRIG_FRAC_BITS;

	always_ff @(posedge clk) begin
		d_s2[0] <= TW'(d0_full);
		d_s2[1] <= TW'(d1_full);
		d_s2[2] <= cp_s1;
	end

	// matrix times direction
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			coef[0][j] = $signed(cfg.row_zero[CW*j +: CW]);
			coef[1][j] = $signed(cfg.row_one[CW*j +: CW]);
			coef[2][j] = $signed(cfg.row_two[CW*j +: CW]);
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int j = 0; j < 3; j++) begin
				term_s3[r][j] <= coef[r][j] * d_s2[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			proj_s4[r] <= PW'(term_s3[r][0]) + PW'(term_s3[r][1]) + PW'(term_s3[r][2]);
		end
	end

	// mirror offset and bounds scaled by w
	assign sw_m1 = $signed({1'b0, cfg.width} - (e2p_pkg::SIZE_W + 1)'(1));

	always_ff @(posedge clk) begin
		cm_s5 <= sw_m1 * proj_s4[2];
		cl_s5 <= $signed({1'b0, cfg.width}) * proj_s4[2];
		rl_s5 <= $signed({1'b0, cfg.height}) * proj_s4[2];
		u_s5  <= proj_s4[0];
		v_s5  <= proj_s4[1];
		w_s5  <= proj_s4[2];
	end

	always_ff @(posedge clk) begin
		ncol_s6 <= XW'(cm_s5) - XW'(u_s5);
		cl_s6   <= XW'(cl_s5);
		rl_s6   <= XW'(rl_s5);
		v_s6    <= XW'(v_s5);
		w_s6    <= XW'(w_s5);
	end

	// classify: w must be positive and each coordinate in range
	assign wpos = !w_s6[XW-1] && (w_s6 != '0);
	assign cin  = wpos && !ncol_s6[XW-1] && (ncol_s6 < cl_s6);
	assign rin  = wpos && !v_s6[XW-1] && (v_s6 < rl_s6);

	always_ff @(posedge clk) begin
		work.col_num    <= cin ? ncol_s6[e2p_pkg::NUM_W-1:0] : '0;
		work.row_num    <= rin ? v_s6[e2p_pkg::NUM_W-1:0] : '0;
		work.w          <= wpos ? w_s6[e2p_pkg::POS_W-1:0] : e2p_pkg::POS_W'(1);
		work.col_inside <= cin;
		work.row_inside <= rin;
	end

	assign out_valid = v_q[e2p_pkg::FRONT_LAT-1];

endmodule

// ===== src/e2p_queue.sv =====
module e2p_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  e2p_pkg::work_t   push_item,
	input  logic             pop,
	output logic             out_valid,
	output e2p_pkg::work_t   out_item,
	output logic             full
);

	e2p_pkg::work_t                entry_q [e2p_pkg::QUEUE_DEPTH];
	logic [e2p_pkg::QPTR_W-1:0]    wr_q;
	logic [e2p_pkg::QPTR_W-1:0]    rd_q;
	logic [e2p_pkg::QPTR_W:0]      count_q;
	logic                          do_push;
	logic                          do_pop;

	assign out_valid = (count_q != '0);
	assign full      = (count_q == (e2p_pkg::QPTR_W + 1)'(e2p_pkg::QUEUE_DEPTH));
	assign do_push   = push && !full;
	assign do_pop    = pop && out_valid;
	assign out_item  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/e2p_back.sv =====
module e2p_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  e2p_pkg::work_t     item,
	output logic               done,
	output e2p_pkg::result_t   result
);

	localparam int Q  = e2p_pkg::QUOT_W;
	localparam int NW = e2p_pkg::NUM_W;

	logic [Q:0]           v_q;
	logic [NW-1:0]        crem_s [1:Q];
	logic [NW-1:0]        rrem_s [1:Q];
	logic [Q-1:0]         cq_s   [1:Q];
	logic [Q-1:0]         rq_s   [1:Q];
	logic [e2p_pkg::POS_W-1:0] w_s [1:Q];
	logic                 cin_s  [1:Q];
	logic                 rin_s  [1:Q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[Q-1:0], in_valid};
		end
	end

	// restoring division, one quotient bit per stage, msb first
	for (genvar k = 0; k < Q; k++) begin : g_div
		logic [NW-1:0]             crem_in, rrem_in, dsh;
		logic [Q-1:0]              cq_in, rq_in;
		logic [e2p_pkg::POS_W-1:0] w_in;
		logic                      cin_in, rin_in;
		logic [NW:0]               ctry, rtry;

		if (k == 0) begin : g_first
			assign crem_in = item.col_num;
			assign rrem_in = item.row_num;
			assign cq_in   = '0;
			assign rq_in   = '0;
			assign w_in    = item.w;
			assign cin_in  = item.col_inside;
			assign rin_in  = item.row_inside;
		end else begin : g_next
			assign crem_in = crem_s[k];
			assign rrem_in = rrem_s[k];
			assign cq_in   = cq_s[k];
			assign rq_in   = rq_s[k];
			assign w_in    = w_s[k];
			assign cin_in  = cin_s[k];
			assign rin_in  = rin_s[k];
		end

		assign dsh  = NW'(w_in) << (Q - 1 - k);
		assign ctry = {1'b0, crem_in} - {1'b0, dsh};
		assign rtry = {1'b0, rrem_in} - {1'b0, dsh};

		always_ff @(posedge clk) begin
			crem_s[k+1] <= ctry[NW] ? crem_in : ctry[NW-1:0];
			rrem_s[k+1] <= rtry[NW] ? rrem_in : rtry[NW-1:0];
			cq_s[k+1]   <= {cq_in[Q-2:0], ~ctry[NW]};
			rq_s[k+1]   <= {rq_in[Q-2:0], ~rtry[NW]};
			w_s[k+1]    <= w_in;
			cin_s[k+1]  <= cin_in;
			rin_s[k+1]  <= rin_in;
		end
	end

	// saturate quotients above the field range
	always_ff @(posedge clk) begin
		result.source_col <= cq_s[Q][Q-1] ? '1 : cq_s[Q][e2p_pkg::COORD_W-1:0];
		result.source_row <= rq_s[Q][Q-1] ? '1 : rq_s[Q][e2p_pkg::COORD_W-1:0];
		result.col_inside <= cin_s[Q];
		result.row_inside <= rin_s[Q];
	end

	assign done = v_q[Q];

endmodule

// ===== tb/equirect_to_pinhole_mapper_test.sv =====
`timescale 1ns / 100ps

// keeps the configuration copy, computes the source pixel of each taken item
// and compares it with what the block gives
class source_pixel_scoreboard;
	logic [e2p_pkg::CFG_W-1:0]  mat_row[3];
	logic [e2p_pkg::SIZE_W-1:0] src_w;
	logic [e2p_pkg::SIZE_W-1:0] src_h;
	e2p_pkg::result_t           pending_pixels[$];
	int                         errors;
	longint                     atan_tab[e2p_pkg::CORDIC_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1};

	function new();
		mat_row = '{default: '0};
		src_w = e2p_pkg::SIZE_W'(720);
		src_h = e2p_pkg::SIZE_W'(1280);
		errors = 0;
	endfunction

	function void write_reg(int idx, logic [e2p_pkg::CFG_W-1:0] data);
		case (idx)
			e2p_pkg::REG_ROW_ZERO: mat_row[0] = data;
			e2p_pkg::REG_ROW_ONE: mat_row[1] = data;
			e2p_pkg::REG_ROW_TWO: mat_row[2] = data;
			e2p_pkg::REG_SRC_WIDTH: src_w = data[e2p_pkg::SIZE_W-1:0];
			e2p_pkg::REG_SRC_HEIGHT: src_h = data[e2p_pkg::SIZE_W-1:0];
			default: ;
		endcase
	endfunction

	// sine and cosine of idx*pi/PANO_HEIGHT through a 30 step cordic
	function void sin_cos(longint unsigned idx, output longint sn, output longint cs);
		longint unsigned r, a;
		bit flip;
		longint x, y, z, dx, dy;
		r = idx % (2 * e2p_pkg::PANO_HEIGHT);
		a = (r << 31) / e2p_pkg::PANO_HEIGHT;
		flip = 0;
		if (a >= 64'h4000_0000 && a < 64'hC000_0000) begin
			a = (a - 64'h8000_0000) & 64'hFFFF_FFFF;
			flip = 1;
		end
		z = (a >= 64'h8000_0000) ? longint'(a) - 64'sh1_0000_0000 : longint'(a);
		x = longint'(e2p_pkg::CORDIC_GAIN_Q30);
		y = 0;
		for (int i = 0; i < e2p_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tab[i];
			end else begin
				x += dx; y -= dy; z += atan_tab[i];
			end
		end
		x = (x + (64'sd1 <<< (e2p_pkg::RND_SHIFT - 1))) >>> e2p_pkg::RND_SHIFT;
		y = (y + (64'sd1 <<< (e2p_pkg::RND_SHIFT - 1))) >>> e2p_pkg::RND_SHIFT;
		cs = flip ? -x : x;
		sn = flip ? -y : y;
	endfunction

	function longint row_dot(logic [e2p_pkg::CFG_W-1:0] r, longint d0, longint d1, longint d2);
		logic signed [e2p_pkg::COEF_W-1:0] c0, c1, c2;
		c0 = r[0 +: e2p_pkg::COEF_W];
		c1 = r[e2p_pkg::COEF_W +: e2p_pkg::COEF_W];
		c2 = r[2*e2p_pkg::COEF_W +: e2p_pkg::COEF_W];
		return longint'(c0) * d0 + longint'(c1) * d1 + longint'(c2) * d2;
	endfunction

	// floor(num/w) if 0 <= num/w < lim, saturated to the field
	function logic [e2p_pkg::COORD_W-1:0] place(longint num, longint w, longint lim,
		output logic flag);
		longint q;
		flag = 0;
		if (num < 0 || num >= lim * w)
			return '0;
		flag = 1;
		q = num / w;
		return (q > 4095) ? 12'd4095 : q[e2p_pkg::COORD_W-1:0];
	endfunction

	function void note_item(e2p_pkg::pano_t p);
		longint st, ct, sp, cp, d0, d1, d2, u, v, w;
		e2p_pkg::result_t r;
		sin_cos(longint'(p.pano_col) + e2p_pkg::PANO_HEIGHT, st, ct);
		sin_cos(longint'(p.pano_row), sp, cp);
		d0 = (ct * sp + (64'sd1 <<< (e2p_pkg::TRIG_FRAC_BITS - 1))) >>> e2p_pkg::TRIG_FRAC_BITS;
		d1 = (st * sp + (64'sd1 <<< (e2p_pkg::TRIG_FRAC_BITS - 1))) >>> e2p_pkg::TRIG_FRAC_BITS;
		d2 = cp;
		u = row_dot(mat_row[0], d0, d1, d2);
		v = row_dot(mat_row[1], d0, d1, d2);
		w = row_dot(mat_row[2], d0, d1, d2);
		r = '0;
		if (w > 0) begin
			r.source_col = place((longint'(src_w) - 1) * w - u, w, longint'(src_w), r.col_inside);
			r.source_row = place(v, w, longint'(src_h), r.row_inside);
		end
		pending_pixels.insert(pending_pixels.size(), r);
	endfunction

	function void check_pixel(e2p_pkg::result_t got);
		e2p_pkg::result_t exp;
		if (pending_pixels.size() == 0) begin
			$error("result with no item outstanding: %p", got);
			errors++;
			return;
		end
		exp = pending_pixels.pop_front();
		if (got.source_col !== exp.source_col) begin
			$error("source_col expected %0d got %0d", exp.source_col, got.source_col);
			errors++;
		end
		if (got.source_row !== exp.source_row) begin
			$error("source_row expected %0d got %0d", exp.source_row, got.source_row);
			errors++;
		end
		if (got.row_inside !== exp.row_inside) begin
			$error("row_inside expected %0d got %0d", exp.row_inside, got.row_inside);
			errors++;
		end
		if (got.col_inside !== exp.col_inside) begin
			$error("col_inside expected %0d got %0d", exp.col_inside, got.col_inside);
			errors++;
		end
	endfunction

	function int outstanding();
		return pending_pixels.size();
	endfunction
endclass

module equirect_to_pinhole_mapper_test;

	// indexes past the last register, writes there must be dropped
	localparam int FIRST_UNUSED_REG = e2p_pkg::REG_SRC_HEIGHT + 1;
	localparam int LAST_REG_INDEX = (1 << e2p_pkg::CFG_IDX_W) - 1;
	// pipeline depth from start to done, plus margin
	localparam int SETTLE_CYCLES = 70;
	localparam int RANDOM_PHASES = 12;
	localparam int ITEMS_PER_PHASE = 100;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	e2p_pkg::pano_t                pano;
	logic                          done;
	e2p_pkg::result_t              result;
	logic                          cfg_we;
	logic [e2p_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [e2p_pkg::CFG_W-1:0]     cfg_data;

	source_pixel_scoreboard sb = new();
	int idle_bias;

	equirect_to_pinhole_mapper DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pano(pano),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// items and results are sampled before this edge's updates land
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_item(pano);
			if (done)
				sb.check_pixel(result);
		end
	end

	// q12.8 coefficient packed into its 21 bit slot
	function automatic logic [e2p_pkg::COEF_W-1:0] q8(int val);
		return val[e2p_pkg::COEF_W-1:0];
	endfunction

	function automatic logic [e2p_pkg::CFG_W-1:0] pack_row(int c0, int c1, int c2);
		return {q8(c2), q8(c1), q8(c0)};
	endfunction

	task automatic write_reg(int idx, logic [e2p_pkg::CFG_W-1:0] data);
		cfg_we <= 1;
		cfg_index <= idx[e2p_pkg::CFG_IDX_W-1:0];
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// mostly no gap, some short ones, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < idle_bias)
			return 0;
		if (r < 96)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// holds start until the block takes the item; busy only moves at rising edges
	task automatic send_item(e2p_pkg::pano_t p, bit last);
		bit stalled;
		int gap;
		start <= 1;
		pano <= p;
		do begin
			@(negedge clk);
			stalled = busy;
			@(posedge clk);
		end while (stalled);
		gap = last ? 1 : pick_gap();
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_items(int n);
		e2p_pkg::pano_t p;
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0)
				idle_bias = ($urandom_range(3) == 0) ? 100 : 70;
			p.pano_col = 11'($urandom_range(2047));
			p.pano_row = 10'($urandom_range(1023));
			send_item(p, i == n - 1);
		end
	endtask

	// pinhole camera looking along one axis, with random focal, center and skew
	task automatic load_pinhole(int wdt, int hgt);
		int ax, bx, kx, sgn, fx, fy, cx, cy;
		int r0[3], r1[3], r2[3];
		ax = $urandom_range(2);
		bx = (ax + 1 + $urandom_range(1)) % 3;
		kx = 3 - ax - bx;
		sgn = $urandom_range(1) ? 1 : -1;
		fx = $urandom_range(1500, 20) * 256 + $urandom_range(255);
		fy = $urandom_range(1500, 20) * 256 + $urandom_range(255);
		cx = (wdt / 2) * 256 + $urandom_range(255);
		cy = (hgt / 2) * 256 + $urandom_range(255);
		for (int j = 0; j < 3; j++) begin
			r0[j] = $urandom_range(100) - 50;
			r1[j] = $urandom_range(100) - 50;
			r2[j] = $urandom_range(20) - 10;
		end
		r0[ax] += fx;
		r0[kx] += sgn * cx;
		r1[bx] += fy;
		r1[kx] += sgn * cy;
		r2[kx] += sgn * 256;
		write_reg(e2p_pkg::REG_ROW_ZERO, pack_row(r0[0], r0[1], r0[2]));
		write_reg(e2p_pkg::REG_ROW_ONE, pack_row(r1[0], r1[1], r1[2]));
		write_reg(e2p_pkg::REG_ROW_TWO, pack_row(r2[0], r2[1], r2[2]));
		write_reg(e2p_pkg::REG_SRC_WIDTH, e2p_pkg::CFG_W'(wdt));
		write_reg(e2p_pkg::REG_SRC_HEIGHT, e2p_pkg::CFG_W'(hgt));
	endtask

	task automatic directed_items();
		e2p_pkg::pano_t p;
		int cols[8] = '{0, 2047, 1024, 512, 1536, 1, 1023, 1025};
		int rows[8] = '{0, 1023, 512, 256, 1, 511, 513, 768};
		for (int i = 0; i < 8; i++) begin
			p.pano_col = 11'(cols[i]);
			p.pano_row = 10'(rows[(i * 3) % 8]);
			send_item(p, 0);
		end
		for (int i = 0; i < 8; i++) begin
			p.pano_col = 11'(cols[(i * 5) % 8]);
			p.pano_row = 10'(rows[i]);
			send_item(p, i == 7);
		end
	endtask

	initial begin
		logic [e2p_pkg::CFG_W-1:0] junk;
		arst_n = 0;
		start = 0;
		pano = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		idle_bias = 80;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset configuration: zero matrix, so w is never positive
		directed_items();
		wait_idle();

		// sensible camera at the reset sizes, then writes to unused indexes
		load_pinhole(720, 1280);
		for (int idx = FIRST_UNUSED_REG; idx <= LAST_REG_INDEX; idx++)
			write_reg(idx, e2p_pkg::CFG_W'({$urandom, $urandom}));
		directed_items();
		wait_idle();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph % 6)
				0: load_pinhole($urandom_range(4096, 1), $urandom_range(4096, 1));
				// empty bounds on both sides
				1: begin
					load_pinhole(720, 1280);
					write_reg(e2p_pkg::REG_SRC_WIDTH, '0);
					write_reg(e2p_pkg::REG_SRC_HEIGHT, '0);
				end
				// oversized source, coordinates saturate
				2: begin
					load_pinhole(8191, 8191);
					write_reg(e2p_pkg::REG_ROW_ZERO, pack_row($urandom_range(400), 0, 0));
				end
				// coefficient extremes
				3: begin
					junk = (ph < 6) ? pack_row(1048575, 1048575, 1048575)
						: pack_row(-1048576, -1048576, -1048576);
					write_reg(e2p_pkg::REG_ROW_ZERO, junk);
					write_reg(e2p_pkg::REG_ROW_ONE, ~junk);
					write_reg(e2p_pkg::REG_ROW_TWO, junk);
					write_reg(e2p_pkg::REG_SRC_WIDTH, e2p_pkg::CFG_W'((ph < 6) ? 1 : 4096));
					write_reg(e2p_pkg::REG_SRC_HEIGHT, e2p_pkg::CFG_W'((ph < 6) ? 4096 : 1));
				end
				// every bit of the data bus
				4: begin
					write_reg(e2p_pkg::REG_ROW_ZERO, e2p_pkg::CFG_W'({$urandom, $urandom}));
					write_reg(e2p_pkg::REG_ROW_ONE, e2p_pkg::CFG_W'({$urandom, $urandom}));
					write_reg(e2p_pkg::REG_ROW_TWO, e2p_pkg::CFG_W'({$urandom, $urandom}));
					write_reg(e2p_pkg::REG_SRC_WIDTH, e2p_pkg::CFG_W'($urandom));
					write_reg(e2p_pkg::REG_SRC_HEIGHT, e2p_pkg::CFG_W'($urandom));
				end
				default: load_pinhole($urandom_range(2048, 16), $urandom_range(2048, 16));
			endcase
			random_items(ITEMS_PER_PHASE);
			wait_idle();
		end

		if (sb.errors == 0)
			$display("PASS equirect_to_pinhole_mapper");
		else
			$display("FAIL equirect_to_pinhole_mapper");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAIL equirect_to_pinhole_mapper");
		$finish;
	end

endmodule
